### sv/isz_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// isz_pkg
// Shared types, sizes and helpers for the zero-fill image shifter.
// ---------------------------------------------------------------------------
package isz_pkg;

    localparam int MAX_COLS      = 256;
    localparam int MAX_ROWS      = 256;
    localparam int PIXEL_BITS    = 32;

    localparam int COL_BITS      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_BITS      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ADDR_BITS     = COL_BITS + ROW_BITS;
    localparam int STORE_DEPTH   = MAX_COLS * MAX_ROWS;

    localparam int DIM_BITS      = 9;
    localparam int SHIFT_BITS    = 10;
    localparam int SPOS_BITS     = SHIFT_BITS + 1;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 10;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_X_SHIFT      = 2'd2,
        REG_Y_SHIFT      = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic                  mode;
        logic [PIXEL_BITS-1:0] pixel_in;
    } t_cmd;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_out;
        logic                  frame_end;
    } t_result;

    // Store access and side info for one accepted beat
    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_BITS-1:0]  wr_addr;
        logic                  rd_en;
        logic [ADDR_BITS-1:0]  rd_addr;
        logic                  hit;
        logic                  last;
    } t_mem_req;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EMIT = 1'b1;

    // Clamp a size register to 1..max
    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                     input int max_v);
        logic [DIM_BITS-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_BITS'(1);
        end else if (32'(v) > max_v) begin
            r = DIM_BITS'(max_v);
        end
        return r;
    endfunction

endpackage : isz_pkg
`default_nettype wire

### sv/isz_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// isz_ram
// Generic single-write, single-read synchronous RAM, registered read data.
// ---------------------------------------------------------------------------
module isz_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : isz_ram
`default_nettype wire

### sv/isz_seq.sv
`default_nettype none
// ---------------------------------------------------------------------------
// isz_seq
// Config registers, load/emit raster counters and store address generation.
// ---------------------------------------------------------------------------
module isz_seq (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_accept,
    input  wire logic                               i_mode,
    input  wire logic                               i_cfg_we,
    input  wire logic [isz_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [isz_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output isz_pkg::t_mem_req                       o_req
);
    import isz_pkg::*;

    logic [DIM_BITS-1:0]   r_width, r_height;
    logic [SHIFT_BITS-1:0] r_xs, r_ys;
    logic [COL_BITS-1:0]   r_load_col, r_emit_col, n_load_col, n_emit_col;
    logic [ROW_BITS-1:0]   r_load_row, r_emit_row, n_load_row, n_emit_row;

    logic [DIM_BITS-1:0]   w_eff, h_eff;
    logic signed [SPOS_BITS-1:0] sx, sy;
    logic                  in_frame, src_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_BITS'(MAX_COLS);
            r_height <= DIM_BITS'(MAX_ROWS);
            r_xs     <= '0;
            r_ys     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_FRAME_WIDTH:  r_width  <= i_cfg_data[DIM_BITS-1:0];
                REG_FRAME_HEIGHT: r_height <= i_cfg_data[DIM_BITS-1:0];
                REG_X_SHIFT:      r_xs     <= i_cfg_data[SHIFT_BITS-1:0];
                REG_Y_SHIFT:      r_ys     <= i_cfg_data[SHIFT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_col <= '0;
            r_load_row <= '0;
            r_emit_col <= '0;
            r_emit_row <= '0;
        end else begin
            r_load_col <= n_load_col;
            r_load_row <= n_load_row;
            r_emit_col <= n_emit_col;
            r_emit_row <= n_emit_row;
        end
    end

    always_comb begin
        w_eff = clamp_dim(r_width, MAX_COLS);
        h_eff = clamp_dim(r_height, MAX_ROWS);

        // source position = output position minus shift
        sx = $signed(SPOS_BITS'(r_emit_col)) - $signed({r_xs[SHIFT_BITS-1], r_xs});
        sy = $signed(SPOS_BITS'(r_emit_row)) - $signed({r_ys[SHIFT_BITS-1], r_ys});

        in_frame = (DIM_BITS'(r_emit_col) < w_eff) && (DIM_BITS'(r_emit_row) < h_eff);
        src_ok   = !sx[SPOS_BITS-1] && !sy[SPOS_BITS-1]
                && (sx < $signed(SPOS_BITS'(w_eff)))
                && (sy < $signed(SPOS_BITS'(h_eff)));

        n_load_col = r_load_col;
        n_load_row = r_load_row;
        n_emit_col = r_emit_col;
        n_emit_row = r_emit_row;

        if (i_accept && i_mode == MODE_LOAD) begin
            if (DIM_BITS'(r_load_col) + DIM_BITS'(1) >= w_eff) begin
                n_load_col = '0;
                if (DIM_BITS'(r_load_row) + DIM_BITS'(1) >= h_eff) begin
                    n_load_row = '0;
                end else begin
                    n_load_row = r_load_row + ROW_BITS'(1);
                end
            end else begin
                n_load_col = r_load_col + COL_BITS'(1);
            end
        end

        if (i_accept && i_mode == MODE_EMIT) begin
            if (DIM_BITS'(r_emit_col) + DIM_BITS'(1) >= w_eff) begin
                n_emit_col = '0;
                if (DIM_BITS'(r_emit_row) + DIM_BITS'(1) >= h_eff) begin
                    n_emit_row = '0;
                end else begin
                    n_emit_row = r_emit_row + ROW_BITS'(1);
                end
            end else begin
                n_emit_col = r_emit_col + COL_BITS'(1);
            end
        end

        o_req.wr_en   = i_accept && (i_mode == MODE_LOAD);
        o_req.wr_addr = {r_load_row, r_load_col};
        o_req.rd_en   = i_accept && (i_mode == MODE_EMIT);
        o_req.rd_addr = {sy[ROW_BITS-1:0], sx[COL_BITS-1:0]};
        o_req.hit     = in_frame && src_ok;
        o_req.last    = in_frame
                     && (DIM_BITS'(r_emit_col) == w_eff - DIM_BITS'(1))
                     && (DIM_BITS'(r_emit_row) == h_eff - DIM_BITS'(1));
    end

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_req.rd_en && o_req.last) |=> (r_emit_col == '0 && r_emit_row == '0))
        else $error("emit position did not wrap after last pixel");

    a_load_keeps_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.wr_en |=> ($stable(r_emit_col) && $stable(r_emit_row)))
        else $error("load beat moved the emit position");

endmodule : isz_seq
`default_nettype wire

### sv/image_shift_zero_fill.sv
`default_nettype none
// ---------------------------------------------------------------------------
// image_shift_zero_fill
// Frame store with shifted, zero-filled raster readout.
// ---------------------------------------------------------------------------
// Throughput: one beat per cycle, load or emit, while o_busy is low; o_busy is high
//   in reset and goes low once r_up is set after reset, staying low otherwise.
// An emit beat's result strobes o_valid in the cycle after acceptance,
//   through the registered read port of the frame store.
// Load beats produce no result. The receiver cannot stall the output.
// Reset clears counters and config; frame store contents stay undefined.
module image_shift_zero_fill (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire isz_pkg::t_cmd                      i_cmd,
    output logic                                    o_busy,
    output logic                                    o_valid,
    output isz_pkg::t_result                        o_result,
    input  wire logic                               i_cfg_we,
    input  wire logic [isz_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [isz_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import isz_pkg::*;

    t_mem_req              req;
    logic                  accept;
    logic [PIXEL_BITS-1:0] rd_data;
    logic                  r_up, r_valid, r_hit, r_last;

    assign accept = i_start && !o_busy;
    assign o_busy = !r_up;

    isz_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_mode     (i_cmd.mode),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_req      (req)
    );

    // One beat per cycle, so a read never meets a write of the same cycle;
    // a load lands at the edge before any later emit reads.
    isz_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (req.wr_en),
        .i_waddr (req.wr_addr),
        .i_wdata (i_cmd.pixel_in),
        .i_re    (req.rd_en),
        .i_raddr (req.rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_up    <= 1'b1;
            r_valid <= req.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit  <= req.hit;
        r_last <= req.last;
    end

    assign o_valid            = r_valid;
    assign o_result.pixel_out = r_hit ? rd_data : '0;
    assign o_result.frame_end = r_valid && r_last;

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept && i_cmd.mode == MODE_EMIT))
        else $error("result strobe without an emit beat");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.mode == MODE_LOAD) |=> !o_valid)
        else $error("load beat produced a result");

    a_end_with_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.frame_end |-> o_valid)
        else $error("frame_end outside a result beat");

endmodule : image_shift_zero_fill
`default_nettype wire

### tb/tb_image_shift_zero_fill.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_image_shift_zero_fill
// Self-checking bench for the zero-fill image shifter. Source frames are
// loaded under many geometries and read back shifted. Every output beat is
// compared against a raster model of the frame store kept in the bench.
// ----------------------------------------------------------------------------
module tb_image_shift_zero_fill;
    import isz_pkg::*;

    localparam int RANDOM_ITEMS = 220;
    localparam int CALM_TAIL    = 60;
    localparam int MAX_REPORTS  = 10;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_start    = 1'b0;
    t_cmd                     i_cmd      = '0;
    logic                     i_cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     o_busy;
    logic                     o_valid;
    t_result                  o_result;

    image_shift_zero_fill dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_cmd      (i_cmd),
        .o_busy     (o_busy),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Raster model of the shifter
    logic [DIM_BITS-1:0]   cfg_width  = 9'd256;
    logic [DIM_BITS-1:0]   cfg_height = 9'd256;
    int                    shift_x    = 0;
    int                    shift_y    = 0;
    int                    load_col   = 0;
    int                    load_row   = 0;
    int                    emit_col   = 0;
    int                    emit_row   = 0;
    logic [PIXEL_BITS-1:0] src_frame   [STORE_DEPTH];
    bit                    src_written [STORE_DEPTH];
    t_result               expected_pixels [$];

    int err_count  = 0;
    int items_sent = 0;
    bit gaps_on    = 1'b1;

    function automatic int active_size(input logic [DIM_BITS-1:0] v, input int max_v);
        if (v == '0) return 1;
        if (int'(v) > max_v) return max_v;
        return int'(v);
    endfunction

    // Source of the next emit beat; hit low means zero fill
    function automatic void emit_source(output bit hit, output bit last, output int addr);
        int w, h, sx, sy;
        bit in_frame;
        w = active_size(cfg_width, MAX_COLS);
        h = active_size(cfg_height, MAX_ROWS);
        in_frame = emit_col < w && emit_row < h;
        sx = emit_col - shift_x;
        sy = emit_row - shift_y;
        hit = in_frame && sx >= 0 && sy >= 0 && sx < w && sy < h;
        last = in_frame && emit_col == w - 1 && emit_row == h - 1;
        addr = sy * MAX_COLS + sx;
    endfunction

    // A counter past a shrunk size still wraps at its next advance
    function automatic void raster_advance(inout int col, inout int row);
        if (col + 1 >= active_size(cfg_width, MAX_COLS)) begin
            col = 0;
            row = (row + 1 >= active_size(cfg_height, MAX_ROWS)) ? 0 : row + 1;
        end else begin
            col = col + 1;
        end
    endfunction

    function automatic void predict_shifted_pixel(input t_cmd c);
        bit hit, last;
        int addr;
        t_result r;
        if (c.mode == MODE_LOAD) begin
            src_frame[load_row * MAX_COLS + load_col] = c.pixel_in;
            src_written[load_row * MAX_COLS + load_col] = 1'b1;
            raster_advance(load_col, load_row);
        end else begin
            emit_source(hit, last, addr);
            r.pixel_out = '0;
            if (hit) r.pixel_out = src_frame[addr];
            r.frame_end = last;
            expected_pixels.push_back(r);
            raster_advance(emit_col, emit_row);
        end
    endfunction

    function automatic logic [PIXEL_BITS-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic idle_burst(input int n);
        i_start <= 1'b0;
        i_cmd <= '{mode: 1'($urandom), pixel_in: $urandom};
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_beat(input logic mode, input logic [PIXEL_BITS-1:0] pixel);
        bit hit, last;
        int addr;
        t_cmd c;
        c.mode = mode;
        c.pixel_in = pixel;
        // store entries are undefined until loaded: turn such a read into a load
        if (mode == MODE_EMIT) begin
            emit_source(hit, last, addr);
            if (hit && !src_written[addr]) c.mode = MODE_LOAD;
        end
        i_start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_shifted_pixel(c);
        items_sent++;
        if (gaps_on && $urandom_range(0, 4) == 0) idle_burst($urandom_range(1, 6));
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_geometry(input int w, input int h, input int xs, input int ys);
        logic [CFG_DATA_BITS-1:0] vals [4];
        t_cfg_reg r;
        vals = '{CFG_DATA_BITS'(w), CFG_DATA_BITS'(h), CFG_DATA_BITS'(xs),
                 CFG_DATA_BITS'(ys)};
        wait_idle();
        i_cfg_we <= 1'b1;
        for (int k = 0; k < 4; k++) begin
            r = t_cfg_reg'(k);
            i_cfg_idx <= r;
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            case (r)
                REG_FRAME_WIDTH:  cfg_width = vals[k][DIM_BITS-1:0];
                REG_FRAME_HEIGHT: cfg_height = vals[k][DIM_BITS-1:0];
                REG_X_SHIFT:      shift_x = int'($signed(vals[k]));
                REG_Y_SHIFT:      shift_y = int'($signed(vals[k]));
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    // Load-then-read sequence with a few stray beats mixed in
    task automatic run_phase(input int w, input int h, input int xs, input int ys);
        int area, n;
        set_geometry(w, h, xs, ys);
        area = active_size(cfg_width, MAX_COLS) * active_size(cfg_height, MAX_ROWS);
        n = 2 * area + 2 + int'($urandom_range(0, 3));
        for (int k = 0; k < n; k++) begin
            if (k <= area)
                send_beat(($urandom_range(0, 9) == 0) ? MODE_EMIT : MODE_LOAD, rand_pixel());
            else
                send_beat(($urandom_range(0, 6) == 0) ? MODE_LOAD : MODE_EMIT, rand_pixel());
        end
    endtask

    task automatic test_reset_state();
        // 256x256, no shift: the first pixel reads back in place
        send_beat(MODE_LOAD, 32'h1234_5678);
        send_beat(MODE_EMIT, rand_pixel());
    endtask

    task automatic test_small_frame();
        set_geometry(2, 2, 0, 0);
        send_beat(MODE_LOAD, 32'h0000_0000);
        send_beat(MODE_LOAD, 32'hFFFF_FFFF);
        send_beat(MODE_LOAD, 32'hAAAA_AAAA);
        send_beat(MODE_LOAD, 32'h5555_5555);
        repeat (4) send_beat(MODE_EMIT, rand_pixel());
    endtask

    task automatic test_shift_edges();
        set_geometry(2, 2, 1, -1);
        repeat (4) send_beat(MODE_EMIT, rand_pixel());
        // shift equal to the width leaves nothing covered
        set_geometry(2, 2, 2, 0);
        send_beat(MODE_EMIT, rand_pixel());
        set_geometry(2, 2, -512, 511);
        send_beat(MODE_EMIT, rand_pixel());
    endtask

    task automatic test_size_clamp();
        // zero sizes act as 1x1; emit counter starts outside the frame
        set_geometry(0, 0, 0, 0);
        send_beat(MODE_LOAD, rand_pixel());
        repeat (2) send_beat(MODE_EMIT, rand_pixel());
    endtask

    task automatic test_shrink_mid_frame();
        set_geometry(5, 2, 0, 0);
        repeat (4) send_beat(MODE_LOAD, rand_pixel());
        repeat (4) send_beat(MODE_EMIT, rand_pixel());
        // both counters now sit past the new width
        set_geometry(3, 2, 0, 0);
        send_beat(MODE_LOAD, rand_pixel());
        send_beat(MODE_EMIT, rand_pixel());
        // both counters now sit on a row past the new height
        set_geometry(3, 1, 0, 0);
        send_beat(MODE_LOAD, rand_pixel());
        send_beat(MODE_EMIT, rand_pixel());
    endtask

    task automatic test_full_width();
        // shifted image covers only the last few columns: a full row of emits
        // needs just a handful of loads
        set_geometry(256, 1, 250, 0);
        repeat (8) send_beat(MODE_LOAD, rand_pixel());
        repeat (264) send_beat(MODE_EMIT, rand_pixel());
    endtask

    task automatic test_full_height();
        // 10'h3FF truncates to 9'h1FF in the 9-bit size register and clamps to the maximum
        set_geometry(1, 'h3FF, 0, 0);
        repeat (4) send_beat(MODE_LOAD, rand_pixel());
        repeat (4) send_beat(MODE_EMIT, rand_pixel());
    endtask

    task automatic test_random_geometry();
        int w, h, wa, ha, xs, ys, first_item;
        bit calm;
        first_item = items_sent;
        calm = 1'b0;
        while (!calm || items_sent - first_item < RANDOM_ITEMS) begin
            calm = (items_sent - first_item >= RANDOM_ITEMS - CALM_TAIL);
            gaps_on = !calm && $urandom_range(0, 3) != 0;
            w = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 12));
            h = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 8));
            wa = (w == 0) ? 1 : w;
            ha = (h == 0) ? 1 : h;
            if ($urandom_range(0, 3) == 0) begin
                xs = int'($urandom_range(0, 1023)) - 512;
                ys = int'($urandom_range(0, 1023)) - 512;
            end else begin
                xs = int'($urandom_range(0, 2 * wa + 2)) - wa - 1;
                ys = int'($urandom_range(0, 2 * ha + 2)) - ha - 1;
            end
            run_phase(w, h, xs, ys);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid) begin
            if (expected_pixels.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: result beat with none pending: pixel %h end %b",
                             $time, o_result.pixel_out, o_result.frame_end);
            end else begin
                want = expected_pixels.pop_front();
                if (o_result.pixel_out !== want.pixel_out ||
                    o_result.frame_end !== want.frame_end) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: mismatch: expected pixel %h end %b, got pixel %h end %b",
                                 $time, want.pixel_out, want.frame_end,
                                 o_result.pixel_out, o_result.frame_end);
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_small_frame();
        test_shift_edges();
        test_size_clamp();
        test_shrink_mid_frame();
        test_full_width();
        test_full_height();
        test_random_geometry();
        i_start <= 1'b0;
        for (int k = 0; k < 200 && expected_pixels.size() != 0; k++) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (expected_pixels.size() != 0)
            $display("%0d expected results never arrived", expected_pixels.size());
        if (err_count == 0 && expected_pixels.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
sv/isz_pkg.sv
sv/isz_ram.sv
sv/isz_seq.sv
sv/image_shift_zero_fill.sv
tb/tb_image_shift_zero_fill.sv
